### src/linear_probe_hash_set_core_assert.svh
// ---------------------------------------------------------------------------
// assertion macros for the hash set core
// ---------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_SET_CORE_ASSERT_SVH

// same-cycle implication
`define LPS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define LPS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/lps_pkg.sv
// ---------------------------------------------------------------------------
// lps_pkg
// shared constants and types of the linear probing hash set
// ---------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned LOG2_SLOTS_DEF = 10;
  localparam logic [31:0] HASH_MULT      = 32'h9E37_79B9;
  localparam logic [3:0]  TB_RESET       = 4'd10;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_SPARE  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_PRESENT  = 3'd1,
    ST_REMOVED  = 3'd2,
    ST_NOTFOUND = 3'd3,
    ST_FOUND    = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

endpackage

### src/lps_ifs.sv
// ---------------------------------------------------------------------------
// lps channel interfaces
// valid/ready channels for requests, results and the size register
// ---------------------------------------------------------------------------
interface lps_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [31:0] key;
  modport source (output valid, output action, output key, input ready);
  modport sink   (input valid, input action, input key, output ready);
endinterface

interface lps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [9:0]  slot;
  logic [9:0]  occupancy;
  modport source (output valid, output status, output slot, output occupancy, input ready);
  modport sink   (input valid, input status, input slot, input occupancy, output ready);
endinterface

interface lps_cfg_if;
  logic       valid;
  logic       ready;
  logic [3:0] table_bits;
  modport source (output valid, output table_bits, input ready);
  modport sink   (input valid, input table_bits, output ready);
endinterface

### src/lps_mem.sv
// ---------------------------------------------------------------------------
// lps_mem
// slot table: one write port, one read port, registered read data
// ---------------------------------------------------------------------------
module lps_mem #(
  parameter int unsigned AW = 10,
  parameter int unsigned DW = 33
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/lps_hash.sv
// ---------------------------------------------------------------------------
// lps_hash
// multiplicative hash: registered product, home slot from its top bits
// ---------------------------------------------------------------------------
module lps_hash #(
  parameter int unsigned AW   = 10,
  parameter int unsigned TB_W = 4
) (
  input  logic            clk,
  input  logic [31:0]     key,
  input  logic [TB_W-1:0] tb,
  input  logic [AW-1:0]   mask,
  output logic [AW-1:0]   home
);

  logic [31:0] prod_r;
  logic [31:0] shifted;

  always_ff @(posedge clk) begin
    prod_r <= key * lps_pkg::HASH_MULT;
  end

  assign shifted = prod_r >> (6'd32 - 6'(tb));
  assign home    = AW'(shifted) & mask;

endmodule

### src/linear_probe_hash_set_core.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_set_core
// set of 32-bit keys in an open-addressed table with linear probing
// ---------------------------------------------------------------------------
// channel   dir  word
// in_chan   in   action, key
// out_chan  out  status, slot, occupancy
// cfg_chan  in   table_bits (clears the table)
//
// an operation passes S_HASH and S_HOME, then reads one probed slot per step
// in S_PROBE; a remove then scans on in S_RSCAN up to the empty slot that
// ends the scan, with S_RHOME for each entry scanned past the hole and
// S_RHOLE for each entry moved back; the hash product is registered and one slot is read per cycle
// after reset and after each table_bits write a clear pass writes all
// 2^LOG2_SLOTS slots, during which no request is taken
// a finished result waits in the output register while a new request is taken
`include "linear_probe_hash_set_core_assert.svh"

module linear_probe_hash_set_core #(
  parameter int unsigned LOG2_SLOTS = lps_pkg::LOG2_SLOTS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  lps_in_if.sink    in_chan,
  lps_out_if.source out_chan,
  lps_cfg_if.sink   cfg_chan
);

  localparam int unsigned AW   = LOG2_SLOTS;
  localparam int unsigned TB_W = $clog2(LOG2_SLOTS + 1);
  localparam int unsigned DW   = 33;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_HASH  = 8'b0000_0100,
    S_HOME  = 8'b0000_1000,
    S_PROBE = 8'b0001_0000,
    S_RSCAN = 8'b0010_0000,
    S_RHOME = 8'b0100_0000,
    S_RHOLE = 8'b1000_0000
  } state_t;

  state_t              state_r, state_nxt;
  logic [TB_W-1:0]     tb_r, tb_nxt, cfg_tb;
  logic [AW-1:0]       count_r, count_nxt;
  logic [AW-1:0]       ptr_r, ptr_nxt;
  logic [AW-1:0]       j_r, j_nxt;
  logic [AW-1:0]       slot_r, slot_nxt;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [1:0]          action_r;
  logic [31:0]         key_r;
  logic [31:0]         mover_r, mover_nxt;
  lps_pkg::status_t    status_r, status_nxt;
  logic                done_r, done_nxt;
  logic                out_valid_r, out_valid_nxt;
  lps_pkg::status_t    out_status_r;
  logic [9:0]          out_slot_r, out_occ_r;

  logic [AW-1:0]       mask, half, home, prev, r_home;
  logic [31:0]         hash_key;
  logic                we;
  logic [AW-1:0]       waddr, raddr;
  logic [DW-1:0]       wdata, rdata;
  logic                r_used, hit, probe_end, stay, in_acc, cfg_acc, load_out;
  logic [31:0]         r_key;

  assign mask   = (AW'(1) << tb_r) - AW'(1);
  assign half   = AW'(1) << (tb_r - TB_W'(1));
  assign prev   = (ptr_r - AW'(1)) & mask;
  assign r_used = rdata[DW-1];
  assign r_key  = rdata[31:0];
  assign hit    = r_used && (r_key == key_r);
  assign probe_end = !r_used || hit;
  assign r_home = home;

  assign in_chan.ready  = (state_r == S_IDLE) && !done_r;
  assign cfg_chan.ready = 1'b1;
  assign in_acc  = in_chan.valid && in_chan.ready;
  assign cfg_acc = cfg_chan.valid;

  always_comb begin
    cfg_tb = TB_W'(cfg_chan.table_bits);
    if (cfg_chan.table_bits == 4'd0) begin
      cfg_tb = TB_W'(1);
    end else if (32'(cfg_chan.table_bits) > LOG2_SLOTS) begin
      cfg_tb = TB_W'(LOG2_SLOTS);
    end
  end

  assign hash_key = (state_r == S_RSCAN) ? r_key : key_r;

  lps_hash #(.AW(AW), .TB_W(TB_W)) u_hash (
    .clk  (clk),
    .key  (hash_key),
    .tb   (tb_r),
    .mask (mask),
    .home (home)
  );

  assign raddr = (state_r == S_HOME) ? home : prev;

  lps_mem #(.AW(AW), .DW(DW)) u_mem (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // r lies cyclically in [i, j): the entry may stay where it is
  always_comb begin
    stay = ((ptr_r <= r_home) && (r_home < j_r)) ||
           ((r_home < j_r) && (j_r < ptr_r)) ||
           ((j_r < ptr_r) && (ptr_r <= r_home));
  end

  assign load_out = done_r && (!out_valid_r || out_chan.ready);

  always_comb begin
    state_nxt  = state_r;
    tb_nxt     = tb_r;
    count_nxt  = count_r;
    ptr_nxt    = ptr_r;
    j_nxt      = j_r;
    slot_nxt   = slot_r;
    clr_nxt    = clr_r;
    mover_nxt  = mover_r;
    status_nxt = status_r;
    done_nxt   = done_r;
    we         = 1'b0;
    waddr      = ptr_r;
    wdata      = '0;
    if (load_out) begin
      done_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLEAR: begin
        we    = 1'b1;
        waddr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == {AW{1'b1}}) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_HASH;
        end
      end
      S_HASH: state_nxt = S_HOME;
      S_HOME: begin
        ptr_nxt   = home;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (!probe_end) begin
          ptr_nxt = prev;
        end else begin
          slot_nxt  = ptr_r;
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
          case (action_r)
            lps_pkg::ACT_INSERT: begin
              if (hit) begin
                status_nxt = lps_pkg::ST_PRESENT;
              end else if (count_r >= half) begin
                status_nxt = lps_pkg::ST_FULL;
              end else begin
                we         = 1'b1;
                wdata      = {1'b1, key_r};
                count_nxt  = count_r + AW'(1);
                status_nxt = lps_pkg::ST_INSERTED;
              end
            end
            lps_pkg::ACT_REMOVE: begin
              if (hit) begin
                we         = 1'b1;
                j_nxt      = ptr_r;
                ptr_nxt    = prev;
                status_nxt = lps_pkg::ST_REMOVED;
                state_nxt  = S_RSCAN;
                done_nxt   = 1'b0;
              end else begin
                status_nxt = lps_pkg::ST_NOTFOUND;
              end
            end
            default: begin
              status_nxt = hit ? lps_pkg::ST_FOUND : lps_pkg::ST_NOTFOUND;
            end
          endcase
        end
      end
      S_RSCAN: begin
        if (!r_used) begin
          count_nxt = count_r - AW'(1);
          state_nxt = S_IDLE;
          done_nxt  = 1'b1;
        end else begin
          mover_nxt = r_key;
          state_nxt = S_RHOME;
        end
      end
      S_RHOME: begin
        if (stay) begin
          ptr_nxt   = prev;
          state_nxt = S_RSCAN;
        end else begin
          // pull the entry back into the hole
          we        = 1'b1;
          waddr     = j_r;
          wdata     = {1'b1, mover_r};
          j_nxt     = ptr_r;
          state_nxt = S_RHOLE;
        end
      end
      S_RHOLE: begin
        we        = 1'b1;
        ptr_nxt   = prev;
        state_nxt = S_RSCAN;
      end
      default: state_nxt = S_CLEAR;
    endcase
    if (cfg_acc) begin
      tb_nxt    = cfg_tb;
      count_nxt = '0;
      clr_nxt   = '0;
      state_nxt = S_CLEAR;
      done_nxt  = 1'b0;
    end
  end

  assign out_valid_nxt = load_out || (out_valid_r && !out_chan.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      tb_r        <= (LOG2_SLOTS < 32'(lps_pkg::TB_RESET)) ? TB_W'(LOG2_SLOTS)
                                                           : TB_W'(lps_pkg::TB_RESET);
      count_r     <= '0;
      clr_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tb_r        <= tb_nxt;
      count_r     <= count_nxt;
      clr_r       <= clr_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    j_r      <= j_nxt;
    slot_r   <= slot_nxt;
    mover_r  <= mover_nxt;
    status_r <= status_nxt;
    if (in_acc) begin
      action_r <= in_chan.action;
      key_r    <= in_chan.key;
    end
    if (load_out) begin
      out_status_r <= status_r;
      out_slot_r   <= 10'(slot_r);
      out_occ_r    <= 10'(count_r);
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_status_r;
  assign out_chan.slot      = out_slot_r;
  assign out_chan.occupancy = out_occ_r;

  `LPS_ASSERT_NEXT(a_cfg_clears, clk, rst_n, cfg_chan.valid, (count_r == '0) && (state_r == S_CLEAR), "size write did not clear the table")
  `LPS_ASSERT_NOW(a_half_full, clk, rst_n, 1'b1, count_r <= half, "occupancy above half the table")
  `LPS_ASSERT_NEXT(a_accept_hash, clk, rst_n, in_chan.valid && in_chan.ready && !cfg_chan.valid, state_r == S_HASH, "request accepted without starting a probe")
  `LPS_ASSERT_NOW(a_tb_range, clk, rst_n, 1'b1, (tb_r != '0) && (32'(tb_r) <= LOG2_SLOTS), "table size out of range")

endmodule

### tb/sv/linear_probe_hash_set_core_tb.sv
// ---------------------------------------------------------------------------
// linear_probe_hash_set_core_tb
// drives insert, remove, lookup and spare words into the hash set core, predicts
// each result with a software copy of the table and compares field by field
// ---------------------------------------------------------------------------
module linear_probe_hash_set_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NSLOT = 1 << lps_pkg::LOG2_SLOTS_DEF;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  lps_in_if  in_chan();
  lps_out_if out_chan();
  lps_cfg_if cfg_chan();

  linear_probe_hash_set_core uut (
    .clk(clk), .rst_n(rst_n),
    .in_chan(in_chan), .out_chan(out_chan), .cfg_chan(cfg_chan)
  );

  typedef struct packed {
    lps_pkg::status_t status;
    logic [9:0]       slot;
    logic [9:0]       occupancy;
  } hash_result_t;

  typedef struct {
    lps_pkg::action_t act;
    logic [31:0]      key;
    logic             known;
    lps_pkg::status_t status;
    logic [9:0]       slot;
    logic [9:0]       occupancy;
  } dir_row_t;

  // shadow table
  logic        shadow_used [NSLOT];
  logic [31:0] shadow_key  [NSLOT];
  int unsigned shadow_count;
  int unsigned shadow_bits;

  hash_result_t pending_results[$];
  int errors = 0;
  int results_seen = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_off = 0;

  function automatic int unsigned size_mask();
    return (1 << shadow_bits) - 1;
  endfunction

  function automatic int unsigned hash_home(logic [31:0] k);
    logic [31:0] p;
    p = k * lps_pkg::HASH_MULT;
    return (p >> (32 - shadow_bits)) & size_mask();
  endfunction

  function automatic void shadow_clear(logic [3:0] v);
    int unsigned b;
    b = v;
    if (b < 1) b = 1;
    if (b > lps_pkg::LOG2_SLOTS_DEF) b = lps_pkg::LOG2_SLOTS_DEF;
    shadow_bits = b;
    for (int i = 0; i < NSLOT; i++) begin
      shadow_used[i] = 1'b0;
      shadow_key[i] = '0;
    end
    shadow_count = 0;
  endfunction

  // knuth algorithm r: pull later entries back over the hole
  function automatic void shadow_delete(int unsigned i);
    int unsigned m, j, r, steps;
    m = size_mask();
    steps = 0;
    forever begin
      j = i;
      shadow_used[j] = 1'b0;
      forever begin
        i = (i - 1) & m;
        steps++;
        if (!shadow_used[i] || steps > m) begin
          shadow_count--;
          return;
        end
        r = hash_home(shadow_key[i]);
        if (!((i <= r && r < j) || (r < j && j < i) || (j < i && i <= r))) break;
      end
      shadow_key[j] = shadow_key[i];
      shadow_used[j] = 1'b1;
    end
  endfunction

  function automatic hash_result_t predict_hash_op(lps_pkg::action_t act, logic [31:0] k);
    hash_result_t res;
    int unsigned m, i;
    logic hit;
    m = size_mask();
    i = hash_home(k);
    hit = 1'b0;
    for (int n = 0; n <= m; n++) begin
      if (!shadow_used[i]) break;
      if (shadow_key[i] == k) begin
        hit = 1'b1;
        break;
      end
      i = (i - 1) & m;
    end
    case (act)
      lps_pkg::ACT_INSERT: begin
        if (hit) res.status = lps_pkg::ST_PRESENT;
        else if (shadow_count >= (1 << (shadow_bits - 1))) res.status = lps_pkg::ST_FULL;
        else begin
          shadow_used[i] = 1'b1;
          shadow_key[i] = k;
          shadow_count++;
          res.status = lps_pkg::ST_INSERTED;
        end
      end
      lps_pkg::ACT_REMOVE: begin
        if (hit) begin
          shadow_delete(i);
          res.status = lps_pkg::ST_REMOVED;
        end else res.status = lps_pkg::ST_NOTFOUND;
      end
      default: res.status = hit ? lps_pkg::ST_FOUND : lps_pkg::ST_NOTFOUND;
    endcase
    res.slot = i[9:0];
    res.occupancy = shadow_count[9:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (!rst_n) out_chan.ready <= 1'b0;
    else if (hold_off > 0) begin
      out_chan.ready <= 1'b0;
      hold_off <= hold_off - 1;
    end else out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    hash_result_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result status=%0d", out_chan.status);
      end else begin
        want = pending_results.pop_front();
        if (out_chan.status !== want.status || out_chan.slot !== want.slot ||
            out_chan.occupancy !== want.occupancy) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: want st=%0d slot=%0d occ=%0d got st=%0d slot=%0d occ=%0d",
                     want.status, want.slot, want.occupancy,
                     out_chan.status, out_chan.slot, out_chan.occupancy);
        end
      end
    end
  end

  // valid stays up after the accepting edge until the next word or a drain
  task automatic offer_word(lps_pkg::action_t act, logic [31:0] k);
    in_chan.valid <= 1'b1;
    in_chan.action <= act;
    in_chan.key <= k;
    do @(posedge clk); while (!in_chan.ready);
  endtask

  task automatic send_word(lps_pkg::action_t act, logic [31:0] k);
    if ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    offer_word(act, k);
    pending_results.push_back(predict_hash_op(act, k));
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_size(logic [3:0] v);
    drain();
    cfg_chan.valid <= 1'b1;
    cfg_chan.table_bits <= v;
    do @(posedge clk); while (!cfg_chan.ready);
    cfg_chan.valid <= 1'b0;
    shadow_clear(v);
  endtask

  // keys drawn from a small pool so removes and lookups hit
  function automatic logic [31:0] pick_key(ref logic [31:0] pool[$]);
    logic [31:0] k;
    if (pool.size() > 0 && $urandom_range(99) < 70)
      return pool[$urandom_range(pool.size() - 1)];
    k = $urandom();
    if ($urandom_range(9) == 0) k = ~k;
    pool.push_back(k);
    if (pool.size() > 64) pool.delete(0);
    return k;
  endfunction

  task automatic random_phase(int n, logic [31:0] pool[$]);
    int a;
    for (int i = 0; i < n; i++) begin
      a = $urandom_range(9);
      send_word(a < 5 ? lps_pkg::ACT_INSERT : a < 8 ? lps_pkg::ACT_REMOVE :
                a < 9 ? lps_pkg::ACT_LOOKUP : lps_pkg::ACT_SPARE,
                pick_key(pool));
    end
  endtask

  dir_row_t dir_rows[$];
  logic [31:0] key_pool[$];

  initial begin
    hash_result_t got;
    in_chan.valid = 1'b0;
    in_chan.action = lps_pkg::ACT_LOOKUP;
    in_chan.key = '0;
    cfg_chan.valid = 1'b0;
    cfg_chan.table_bits = lps_pkg::TB_RESET;
    shadow_clear(lps_pkg::TB_RESET);
    send_idle_pct = 14;
    recv_idle_pct = 57;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    dir_rows = '{
      '{lps_pkg::ACT_LOOKUP, 32'h0, 1'b1, lps_pkg::ST_NOTFOUND, 10'd0, 10'd0},
      '{lps_pkg::ACT_REMOVE, 32'hFFFF_FFFF, 1'b0, lps_pkg::ST_NOTFOUND, 10'd0, 10'd0},
      '{lps_pkg::ACT_INSERT, 32'h0, 1'b1, lps_pkg::ST_INSERTED, 10'd0, 10'd1},
      '{lps_pkg::ACT_INSERT, 32'h0, 1'b1, lps_pkg::ST_PRESENT, 10'd0, 10'd1},
      '{lps_pkg::ACT_INSERT, 32'hFFFF_FFFF, 1'b0, lps_pkg::ST_INSERTED, 10'd0, 10'd0},
      '{lps_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, 1'b0, lps_pkg::ST_FOUND, 10'd0, 10'd0},
      '{lps_pkg::ACT_SPARE,  32'h0, 1'b1, lps_pkg::ST_FOUND, 10'd0, 10'd2},
      '{lps_pkg::ACT_INSERT, 32'hAAAA_AAAA, 1'b0, lps_pkg::ST_INSERTED, 10'd0, 10'd0},
      '{lps_pkg::ACT_INSERT, 32'h5555_5555, 1'b0, lps_pkg::ST_INSERTED, 10'd0, 10'd0},
      '{lps_pkg::ACT_REMOVE, 32'h0, 1'b0, lps_pkg::ST_REMOVED, 10'd0, 10'd0},
      '{lps_pkg::ACT_REMOVE, 32'h0, 1'b0, lps_pkg::ST_NOTFOUND, 10'd0, 10'd0},
      '{lps_pkg::ACT_LOOKUP, 32'hAAAA_AAAA, 1'b0, lps_pkg::ST_FOUND, 10'd0, 10'd0}
    };
    foreach (dir_rows[r]) begin
      // the shadow table always advances; typed rows set the expected word
      got = predict_hash_op(dir_rows[r].act, dir_rows[r].key);
      if (dir_rows[r].known) begin
        got.status = dir_rows[r].status;
        got.slot = dir_rows[r].slot;
        got.occupancy = dir_rows[r].occupancy;
      end
      pending_results.push_back(got);
      offer_word(dir_rows[r].act, dir_rows[r].key);
    end

    // smallest table: two slots, one key, then full and wraparound
    write_size(4'd0);
    for (int i = 0; i < 8; i++)
      send_word(i[0] ? lps_pkg::ACT_INSERT : lps_pkg::ACT_REMOVE, $urandom_range(3));
    send_word(lps_pkg::ACT_INSERT, 32'h1);
    send_word(lps_pkg::ACT_INSERT, 32'h2);
    send_word(lps_pkg::ACT_INSERT, 32'h2);

    write_size(4'd3);
    random_phase(200, key_pool);
    // long receiver hold-off while the sender keeps going
    hold_off <= 300;
    random_phase(30, key_pool);
    drain();
    write_size(4'd15);
    random_phase(150, key_pool);

    send_idle_pct = 57;
    recv_idle_pct = 14;
    write_size(4'd2);
    random_phase(150, key_pool);
    write_size(4'd1);
    random_phase(60, key_pool);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_size(4'd10);
    random_phase(100, key_pool);
    write_size(4'd5);
    random_phase(110, key_pool);

    drain();
    repeat (200) @(posedge clk);
    $display("ran %0d results over table sizes 2 to 1024 with stalls", results_seen);
    $display("left over expectations: %0d", pending_results.size());
    if (errors == 0 && pending_results.size() == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
